[rtl/bmr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types and constants of the bit matrix row engine: command and
// status codes, controller states and the controller to datapath bundles.
// ----------------------------------------------------------------------------
package bmr_pkg;

   localparam int BMR_MAX_ROWS  = 64;
   localparam int BMR_ROW_WORDS = 4;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 80;
   localparam int CSR_DATA_W  = 9;

   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_READ  = 3'd1,
      CMD_XOR   = 3'd2,
      CMD_SWAP  = 3'd3,
      CMD_POP   = 3'd4,
      CMD_OR    = 3'd5
   } bmr_code_type;

   typedef enum logic [1:0] {
      STS_OK   = 2'd0,
      STS_ROW  = 2'd1,
      STS_SEG  = 2'd2,
      STS_WORD = 2'd3
   } bmr_status_type;

   typedef enum logic {
      CSR_ROWS_IN_USE = 1'b0,
      CSR_COLS_IN_USE = 1'b1
   } bmr_csr_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ,
      OP_XOR,
      OP_SWAP,
      OP_POP,
      OP_OR1,
      OP_OR2
   } bmr_op_type;

   typedef enum logic [1:0] {
      WSEL_CNT,
      WSEL_INDEX,
      WSEL_DST,
      WSEL_DST1
   } bmr_wsel_type;

   typedef enum logic [2:0] {
      WD_ZERO,
      WD_MASKED,
      WD_XOR,
      WD_RDATA,
      WD_TMP,
      WD_OR_LO,
      WD_OR_HI
   } bmr_wdata_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WRITE,
      ST_READ,
      ST_XOR_RB,
      ST_XOR_RA,
      ST_XOR_WR,
      ST_SWAP_RA,
      ST_SWAP_RB,
      ST_SWAP_WA,
      ST_SWAP_WB,
      ST_POP_RD,
      ST_POP_ACC,
      ST_OR_RD1,
      ST_OR_WR1,
      ST_OR_RD2,
      ST_OR_WR2,
      ST_FINISH
   } bmr_state_type;

   typedef struct packed {
      logic          clear_step;
      logic          capture;
      logic          mem_en;
      logic          mem_we;
      logic          row_sel_b;
      bmr_wsel_type  wsel;
      bmr_wdata_type wdata_sel;
      logic          tmp_load;
      logic          cnt_inc;
      logic          acc_add;
      logic          load_result;
   } bmr_cmd_type;

   typedef struct packed {
      bmr_op_type op;
      logic       clear_done;
      logic       cnt_last_row;
      logic       cnt_last_used;
      logic       out_busy;
   } bmr_sts_type;

endpackage
`default_nettype wire

[rtl/bmr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_datapath
// Matrix store, item and configuration registers, range checks, word
// masking and shifting, popcount accumulator and the result register.
// ----------------------------------------------------------------------------
module bmr_datapath import bmr_pkg::*; #(
   parameter int MAX_ROWS  = BMR_MAX_ROWS,
   parameter int ROW_WORDS = BMR_ROW_WORDS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire bmr_cmd_type            cmd,
   output bmr_sts_type                 sts
);

   localparam int Depth    = MAX_ROWS * ROW_WORDS;
   localparam int AW       = $clog2(Depth);
   localparam int CW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int ColLimit = 64 * ROW_WORDS;

   logic [6:0]  rows_ff;
   logic [8:0]  cols_ff;
   logic [2:0]  code_ff;
   logic [5:0]  ra_ff;
   logic [5:0]  rb_ff;
   logic [1:0]  wi_ff;
   logic [63:0] data_ff;
   logic [8:0]  off_ff;
   logic [8:0]  bits_ff;
   logic [63:0] tmp_ff;
   logic [8:0]  acc_ff;
   logic [CW-1:0] wcnt_ff;
   logic [AW-1:0] clr_ff;
   logic [63:0] rdata_ff;
   logic        rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [63:0] mem [Depth];

   logic [8:0]  nc;
   logic [3:0]  uw;
   logic        row_ok_a;
   logic        row_ok_b;
   logic        off_bad;
   logic        cnt_bad;
   logic [3:0]  nsw;
   logic [3:0]  dst;
   logic [3:0]  dst1;
   logic [5:0]  sh;
   logic        tail_word;
   logic [63:0] seg_data;
   logic [AW-1:0] row_base;
   logic [AW-1:0] word_addr;
   logic [AW-1:0] addr;
   logic [63:0] wdata;
   logic [5:0]  row_sel;
   bmr_op_type     op;
   bmr_status_type st;

   function automatic logic [63:0] col_mask(input logic [8:0] ncols, input logic [3:0] w);
      logic [3:0]  hi;
      logic [63:0] m;
      hi = {1'b0, ncols[8:6]};
      if (hi > w) begin
         m = '1;
      end else if (hi == w) begin
         m = (64'd1 << ncols[5:0]) - 64'd1;
      end else begin
         m = '0;
      end
      return m;
   endfunction

   function automatic logic [6:0] ones64(input logic [63:0] x);
      logic [63:0] p2;
      logic [63:0] p4;
      logic [63:0] p8;
      logic [63:0] p16;
      logic [63:0] p32;
      logic [63:0] p64;
      p2  = x - ((x >> 1) & 64'h5555_5555_5555_5555);
      p4  = (p2 & 64'h3333_3333_3333_3333) + ((p2 >> 2) & 64'h3333_3333_3333_3333);
      p8  = (p4 + (p4 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      p16 = p8 + (p8 >> 8);
      p32 = p16 + (p16 >> 16);
      p64 = p32 + (p32 >> 32);
      return p64[6:0];
   endfunction

   // Configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'd64;
         cols_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (bmr_csr_type'(csr_index))
            CSR_ROWS_IN_USE: rows_ff <= csr_wdata[6:0];
            CSR_COLS_IN_USE: cols_ff <= csr_wdata[8:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= req_tdata[2:0];
         ra_ff   <= req_tdata[8:3];
         rb_ff   <= req_tdata[14:9];
         wi_ff   <= req_tdata[16:15];
         data_ff <= req_tdata[80:17];
         off_ff  <= req_tdata[89:81];
         bits_ff <= req_tdata[98:90];
      end
   end

   // Checks and plan of the held item.
   always_comb begin
      nc       = (int'(cols_ff) < ColLimit) ? cols_ff : 9'(ColLimit);
      uw       = 4'((10'(nc) + 10'd63) >> 6);
      row_ok_a = ({1'b0, ra_ff} < rows_ff) && (int'(ra_ff) < MAX_ROWS);
      row_ok_b = ({1'b0, rb_ff} < rows_ff) && (int'(rb_ff) < MAX_ROWS);
      off_bad  = off_ff > nc;
      cnt_bad  = bits_ff > (nc - off_ff);
      nsw      = 4'((10'(bits_ff) + 10'd63) >> 6);
      dst      = {1'b0, off_ff[8:6]} + {2'b00, wi_ff};
      dst1     = dst + 4'd1;
      sh       = off_ff[5:0];
      tail_word = (bits_ff[5:0] != 6'd0) && (({2'b00, wi_ff} + 4'd1) == nsw);
      seg_data = tail_word ? (data_ff & ((64'd1 << bits_ff[5:0]) - 64'd1)) : data_ff;
   end

   always_comb begin
      op = OP_NONE;
      st = STS_OK;
      priority if (code_ff > CMD_OR) begin
         op = OP_NONE;
      end else if (!row_ok_a ||
                   (((code_ff == CMD_XOR) || (code_ff == CMD_SWAP)) && !row_ok_b)) begin
         st = STS_ROW;
      end else begin
         unique case (bmr_code_type'(code_ff))
            CMD_WRITE, CMD_READ: begin
               if ({2'b00, wi_ff} >= uw) begin
                  st = STS_WORD;
               end else begin
                  op = (code_ff == CMD_WRITE) ? OP_WRITE : OP_READ;
               end
            end
            CMD_XOR: begin
               if (ra_ff != rb_ff) begin
                  op = OP_XOR;
               end
            end
            CMD_SWAP: begin
               if (ra_ff != rb_ff) begin
                  op = OP_SWAP;
               end
            end
            CMD_POP: begin
               if (uw != 4'd0) begin
                  op = OP_POP;
               end
            end
            CMD_OR: begin
               priority if (off_bad || cnt_bad) begin
                  st = STS_SEG;
               end else if (bits_ff == 9'd0) begin
                  op = OP_NONE;
               end else if ({2'b00, wi_ff} >= nsw) begin
                  st = STS_WORD;
               end else if (dst < uw) begin
                  op = ((sh != 6'd0) && (dst1 < uw)) ? OP_OR2 : OP_OR1;
               end else begin
                  op = OP_NONE;
               end
            end
            default: begin
               op = OP_NONE;
            end
         endcase
      end
   end

   // Address and write data.
   always_comb begin
      row_sel  = cmd.row_sel_b ? rb_ff : ra_ff;
      row_base = AW'(row_sel) * AW'(ROW_WORDS);
      unique case (cmd.wsel)
         WSEL_CNT:   word_addr = AW'(wcnt_ff);
         WSEL_INDEX: word_addr = AW'(wi_ff);
         WSEL_DST:   word_addr = AW'(dst);
         WSEL_DST1:  word_addr = AW'(dst1);
         default:    word_addr = '0;
      endcase
      addr = cmd.clear_step ? clr_ff : (row_base + word_addr);
      unique case (cmd.wdata_sel)
         WD_ZERO:   wdata = '0;
         WD_MASKED: wdata = data_ff & col_mask(nc, {2'b00, wi_ff});
         WD_XOR:    wdata = rdata_ff ^ tmp_ff;
         WD_RDATA:  wdata = rdata_ff;
         WD_TMP:    wdata = tmp_ff;
         WD_OR_LO:  wdata = rdata_ff | (seg_data << sh);
         WD_OR_HI:  wdata = rdata_ff | (seg_data >> (7'd64 - {1'b0, sh}));
         default:   wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_en) begin
         if (cmd.mem_we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tmp_load) begin
         tmp_ff <= rdata_ff;
      end
      if (cmd.capture) begin
         acc_ff  <= '0;
         wcnt_ff <= '0;
      end else begin
         if (cmd.acc_add) begin
            acc_ff <= acc_ff + 9'(ones64(rdata_ff & col_mask(nc, 4'(wcnt_ff))));
         end
         if (cmd.cnt_inc) begin
            wcnt_ff <= wcnt_ff + CW'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_data_ff <= {5'b00000, st, acc_ff, (op == OP_READ) ? rdata_ff : 64'd0};
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;
   assign sts.op            = op;
   assign sts.clear_done    = (clr_ff == AW'(Depth - 1));
   assign sts.cnt_last_row  = (wcnt_ff == CW'(ROW_WORDS - 1));
   assign sts.cnt_last_used = ((int'(wcnt_ff) + 1) == int'(uw));
   assign sts.out_busy      = rsp_valid_ff && !rsp_tready;

endmodule
`default_nettype wire

[rtl/bmr_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_controller
// Sequencer of the bit matrix row engine: runs the clearing pass, takes
// one item at a time and steps the datapath through its memory accesses.
// ----------------------------------------------------------------------------
module bmr_controller import bmr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output bmr_cmd_type      cmd,
   input  wire bmr_sts_type sts
);

   bmr_state_type state_ff;
   bmr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:    if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE: begin
            unique case (sts.op)
               OP_NONE:        state_in = ST_FINISH;
               OP_WRITE:       state_in = ST_WRITE;
               OP_READ:        state_in = ST_READ;
               OP_XOR:         state_in = ST_XOR_RB;
               OP_SWAP:        state_in = ST_SWAP_RA;
               OP_POP:         state_in = ST_POP_RD;
               OP_OR1, OP_OR2: state_in = ST_OR_RD1;
               default:        state_in = ST_FINISH;
            endcase
         end
         ST_WRITE:   state_in = ST_FINISH;
         ST_READ:    state_in = ST_FINISH;
         ST_XOR_RB:  state_in = ST_XOR_RA;
         ST_XOR_RA:  state_in = ST_XOR_WR;
         ST_XOR_WR:  state_in = sts.cnt_last_row ? ST_FINISH : ST_XOR_RB;
         ST_SWAP_RA: state_in = ST_SWAP_RB;
         ST_SWAP_RB: state_in = ST_SWAP_WA;
         ST_SWAP_WA: state_in = ST_SWAP_WB;
         ST_SWAP_WB: state_in = sts.cnt_last_row ? ST_FINISH : ST_SWAP_RA;
         ST_POP_RD:  state_in = ST_POP_ACC;
         ST_POP_ACC: state_in = sts.cnt_last_used ? ST_FINISH : ST_POP_RD;
         ST_OR_RD1:  state_in = ST_OR_WR1;
         ST_OR_WR1:  state_in = (sts.op == OP_OR2) ? ST_OR_RD2 : ST_FINISH;
         ST_OR_RD2:  state_in = ST_OR_WR2;
         ST_OR_WR2:  state_in = ST_FINISH;
         ST_FINISH:  if (!sts.out_busy) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.mem_en     = 1'b1;
            cmd.mem_we     = 1'b1;
            cmd.wdata_sel  = WD_ZERO;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_WRITE: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.wsel      = WSEL_INDEX;
            cmd.wdata_sel = WD_MASKED;
         end
         ST_READ: begin
            cmd.mem_en = 1'b1;
            cmd.wsel   = WSEL_INDEX;
         end
         ST_XOR_RB: begin
            cmd.mem_en    = 1'b1;
            cmd.row_sel_b = 1'b1;
            cmd.wsel      = WSEL_CNT;
         end
         ST_XOR_RA: begin
            cmd.mem_en   = 1'b1;
            cmd.wsel     = WSEL_CNT;
            cmd.tmp_load = 1'b1;
         end
         ST_XOR_WR: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.wsel      = WSEL_CNT;
            cmd.wdata_sel = WD_XOR;
            cmd.cnt_inc   = !sts.cnt_last_row;
         end
         ST_SWAP_RA: begin
            cmd.mem_en = 1'b1;
            cmd.wsel   = WSEL_CNT;
         end
         ST_SWAP_RB: begin
            cmd.mem_en    = 1'b1;
            cmd.row_sel_b = 1'b1;
            cmd.wsel      = WSEL_CNT;
            cmd.tmp_load  = 1'b1;
         end
         ST_SWAP_WA: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.wsel      = WSEL_CNT;
            cmd.wdata_sel = WD_RDATA;
         end
         ST_SWAP_WB: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.row_sel_b = 1'b1;
            cmd.wsel      = WSEL_CNT;
            cmd.wdata_sel = WD_TMP;
            cmd.cnt_inc   = !sts.cnt_last_row;
         end
         ST_POP_RD: begin
            cmd.mem_en = 1'b1;
            cmd.wsel   = WSEL_CNT;
         end
         ST_POP_ACC: begin
            cmd.acc_add = 1'b1;
            cmd.cnt_inc = !sts.cnt_last_used;
         end
         ST_OR_RD1: begin
            cmd.mem_en = 1'b1;
            cmd.wsel   = WSEL_DST;
         end
         ST_OR_WR1: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.wsel      = WSEL_DST;
            cmd.wdata_sel = WD_OR_LO;
         end
         ST_OR_RD2: begin
            cmd.mem_en = 1'b1;
            cmd.wsel   = WSEL_DST1;
         end
         ST_OR_WR2: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.wsel      = WSEL_DST1;
            cmd.wdata_sel = WD_OR_HI;
         end
         ST_FINISH: begin
            cmd.load_result = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_result_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !sts.out_busy)
      else $error("result loaded while the output register is still full");

   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_tready && !cmd.capture))
      else $error("item taken during the clearing pass");

   a_second_or_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OR_RD2) |-> (sts.op == OP_OR2))
      else $error("carry word accessed without a carry");

   a_pop_planned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_ACC) |=> ((state_ff == ST_FINISH) || (sts.op == OP_POP)))
      else $error("popcount loop running for another command");

endmodule
`default_nettype wire

[rtl/bit_matrix_row_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bit_matrix_row_engine
// GF(2) bit matrix store with word and row commands, one result per item.
// ----------------------------------------------------------------------------
// After reset the block zeroes its store, one word per cycle, until all
// MAX_ROWS * ROW_WORDS words (256 by default) are clear, and it takes no
// item in that time. It then works on one item at a time on a single-port
// word memory. An item with nothing to do goes straight to its result; a
// word write or read makes one access, a segment OR reads and writes one or
// two words, a popcount reads each used word, a row XOR reads both rows and
// writes row_a word by word, and a row swap reads and writes both rows word
// by word. The result enters the output register in the cycle before the
// next item can be taken, and the next item is taken while the result waits
// there; an item whose result finds that register still full holds in its
// final state until the waiting result is taken.
module bit_matrix_row_engine import bmr_pkg::*; #(
   parameter int MAX_ROWS  = BMR_MAX_ROWS,
   parameter int ROW_WORDS = BMR_ROW_WORDS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // cmd[2:0], row_a[8:3], row_b[14:9], word_index[16:15], data[80:17],
   // seg_start[89:81], seg_bits[98:90], zero fill above.
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_data[63:0], ones_count[72:64], status[74:73], zero fill above.
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   bmr_cmd_type cmd;
   bmr_sts_type sts;

   bmr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   bmr_datapath #(
      .MAX_ROWS  (MAX_ROWS),
      .ROW_WORDS (ROW_WORDS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
`default_nettype wire
